### src/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true -> cons true in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante true -> cons true in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/msfd_pkg.sv
package msfd_pkg;

    localparam int SERVERS    = 8;
    localparam int FIFO_DEPTH = 64;

    localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int CNT_W  = $clog2(SERVERS + 1);
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [7:0] svc_arr_t [SERVERS];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VISIT,
        ST_FINISH
    } msfd_state_t;

    typedef struct packed {
        logic             accept;
        logic             visit;
        logic [SRV_W-1:0] idx;
        logic             finish;
    } msfd_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] active;
        logic             out_free;
    } msfd_sts_t;

endpackage

### src/msfd_ctrl.sv
module msfd_ctrl
    import msfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  msfd_sts_t sts,
    output msfd_cmd_t cmd
);

    msfd_state_t      state_reg, state_next;
    logic [SRV_W-1:0] idx_reg, idx_next;
    logic             last_srv;

    assign last_srv = (CNT_W'(idx_reg) == (sts.active - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    if (sts.active == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_VISIT;
                end
            end
            ST_VISIT:
            begin
                idx_next = idx_reg + SRV_W'(1);
                if (last_srv)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.visit  = 1'b0;
        cmd.finish = 1'b0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_VISIT:
            begin
                cmd.visit = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/msfd_datapath.sv
module msfd_datapath
    import msfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  msfd_cmd_t   cmd,
    output msfd_sts_t   sts,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        arrived,
    input  logic [2:0]  query_server,
    input  svc_arr_t    service_time,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [6:0]  queue_length,
    output logic [31:0] total_arrivals,
    output logic [6:0]  peak_queue_length,
    output logic [47:0] total_wait,
    output logic [31:0] peak_wait,
    output logic [31:0] jobs_started,
    output logic [7:0]  busy_mask,
    output logic        arrival_dropped,
    output logic [31:0] queried_served,
    output logic [39:0] queried_busy_ticks
);

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    logic [3:0]        active_reg;
    logic [31:0]       tick_reg;
    logic [31:0]       now_reg;
    logic [2:0]        query_reg;
    logic [7:0]        svc_reg [SERVERS];
    logic              arr_reg;
    logic [PTR_W-1:0]  head_reg, tail_reg;
    logic [FCNT_W-1:0] count_reg;
    logic [SERVERS-1:0] busy_reg;
    logic [7:0]        rem_reg    [SERVERS];
    logic [31:0]       served_reg [SERVERS];
    logic [39:0]       bticks_reg [SERVERS];
    logic [31:0]       arr_total_reg;
    logic [FCNT_W-1:0] qpeak_reg;
    logic [47:0]       wsum_reg;
    logic [31:0]       wpeak_reg;
    logic [31:0]       start_reg;
    logic              dropped_reg;
    logic              out_valid_reg;

    logic [31:0]       mem [FIFO_DEPTH];
    logic [31:0]       rd_data_reg;

    logic [CNT_W-1:0]  active_sat;
    logic              fifo_full;
    logic              wr_en;
    logic [PTR_W-1:0]  tail_inc, head_inc, rd_addr;
    logic [FCNT_W-1:0] count_push;
    logic              sel_busy;
    logic [7:0]        sel_rem, rem_dec, svc_fix;
    logic              pop;
    logic [31:0]       wait_val;
    logic [48:0]       wsum_add;
    logic [40:0]       bticks_add;

    assign active_sat = (32'(active_reg) > SERVERS) ? CNT_W'(SERVERS) : CNT_W'(active_reg);
    assign sts.active   = active_sat;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;

    assign fifo_full  = (32'(count_reg) == FIFO_DEPTH);
    assign wr_en      = cmd.accept && arrived && !fifo_full;
    assign tail_inc   = (32'(tail_reg) == FIFO_DEPTH - 1) ? '0 : tail_reg + PTR_W'(1);
    assign head_inc   = (32'(head_reg) == FIFO_DEPTH - 1) ? '0 : head_reg + PTR_W'(1);
    assign count_push = count_reg + FCNT_W'(1);

    assign sel_busy   = busy_reg[cmd.idx];
    assign sel_rem    = rem_reg[cmd.idx];
    assign rem_dec    = (sel_rem != 8'd0) ? sel_rem - 8'd1 : 8'd0;
    assign svc_fix    = (svc_reg[cmd.idx] == 8'd0) ? 8'd1 : svc_reg[cmd.idx];
    assign pop        = cmd.visit && !sel_busy && (count_reg != '0);
    assign rd_addr    = pop ? head_inc : head_reg;
    assign wait_val   = now_reg - rd_data_reg;
    assign wsum_add   = {1'b0, wsum_reg} + {17'd0, wait_val};
    assign bticks_add = {1'b0, bticks_reg[cmd.idx]} + {33'd0, svc_fix};

    // read-before-write with bypass keeps rd_data_reg equal to the head entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= tick_reg;
        if (wr_en && (tail_reg == rd_addr))
            rd_data_reg <= tick_reg;
        else
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 4'd8;
            tick_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= '0;
            arr_total_reg <= '0;
            qpeak_reg     <= '0;
            wsum_reg      <= '0;
            wpeak_reg     <= '0;
            start_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SERVERS; i++)
            begin
                rem_reg[i]    <= '0;
                served_reg[i] <= '0;
                bticks_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                active_reg <= cfg_data;

            if (cmd.accept)
            begin
                now_reg     <= tick_reg;
                query_reg   <= query_server;
                arr_reg     <= arrived;
                svc_reg     <= service_time;
                dropped_reg <= arrived && fifo_full;
                if (tick_reg != MAX32)
                    tick_reg <= tick_reg + 32'd1;
                if (wr_en)
                begin
                    tail_reg  <= tail_inc;
                    count_reg <= count_push;
                    if (arr_total_reg != MAX32)
                        arr_total_reg <= arr_total_reg + 32'd1;
                    if (count_push > qpeak_reg)
                        qpeak_reg <= count_push;
                end
            end

            if (cmd.visit)
            begin
                if (sel_busy)
                begin
                    rem_reg[cmd.idx] <= rem_dec;
                    if (rem_dec == 8'd0)
                        busy_reg[cmd.idx] <= 1'b0;
                end
                else if (pop)
                begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - FCNT_W'(1);
                    wsum_reg  <= wsum_add[48] ? '1 : wsum_add[47:0];
                    if (wait_val > wpeak_reg)
                        wpeak_reg <= wait_val;
                    if (start_reg != MAX32)
                        start_reg <= start_reg + 32'd1;
                    busy_reg[cmd.idx] <= 1'b1;
                    rem_reg[cmd.idx]  <= svc_fix;
                    if (served_reg[cmd.idx] != MAX32)
                        served_reg[cmd.idx] <= served_reg[cmd.idx] + 32'd1;
                    bticks_reg[cmd.idx] <= bticks_add[40] ? '1 : bticks_add[39:0];
                end
            end

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            queue_length      <= 7'(count_reg);
            total_arrivals    <= arr_total_reg;
            peak_queue_length <= 7'(qpeak_reg);
            total_wait        <= wsum_reg;
            peak_wait         <= wpeak_reg;
            jobs_started      <= start_reg;
            busy_mask         <= 8'(busy_reg);
            arrival_dropped   <= dropped_reg && arr_reg;
            if (32'(query_reg) < SERVERS)
            begin
                queried_served     <= served_reg[SRV_W'(query_reg)];
                queried_busy_ticks <= bticks_reg[SRV_W'(query_reg)];
            end
            else
            begin
                queried_served     <= '0;
                queried_busy_ticks <= '0;
            end
        end
    end

endmodule

### src/multi_server_fifo_dispatch_top.sv
// An accepted item visits each of the A active servers in turn,
//   A = active server count (0..8), then its result is registered once
//   the output is free. No new item is taken until then: the server
//   visit sequencer shares the single FIFO read port.
// Reset (rst_n low, async): counters zero, FIFO empty, servers idle,
//   active_servers = 8; FIFO storage is not cleared.
module multi_server_fifo_dispatch_top
    import msfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        arrived,
    input  logic [2:0]  query_server,
    input  logic [7:0]  service_time_0,
    input  logic [7:0]  service_time_1,
    input  logic [7:0]  service_time_2,
    input  logic [7:0]  service_time_3,
    input  logic [7:0]  service_time_4,
    input  logic [7:0]  service_time_5,
    input  logic [7:0]  service_time_6,
    input  logic [7:0]  service_time_7,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  queue_length,
    output logic [31:0] total_arrivals,
    output logic [6:0]  peak_queue_length,
    output logic [47:0] total_wait,
    output logic [31:0] peak_wait,
    output logic [31:0] jobs_started,
    output logic [7:0]  busy_mask,
    output logic        arrival_dropped,
    output logic [31:0] queried_served,
    output logic [39:0] queried_busy_ticks
);

    msfd_cmd_t cmd;
    msfd_sts_t sts;
    svc_arr_t  service_time;

    assign service_time[0] = service_time_0;
    assign service_time[1] = service_time_1;
    assign service_time[2] = service_time_2;
    assign service_time[3] = service_time_3;
    assign service_time[4] = service_time_4;
    assign service_time[5] = service_time_5;
    assign service_time[6] = service_time_6;
    assign service_time[7] = service_time_7;

    msfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msfd_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_data           (cfg_data),
        .arrived            (arrived),
        .query_server       (query_server),
        .service_time       (service_time),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .queue_length       (queue_length),
        .total_arrivals     (total_arrivals),
        .peak_queue_length  (peak_queue_length),
        .total_wait         (total_wait),
        .peak_wait          (peak_wait),
        .jobs_started       (jobs_started),
        .busy_mask          (busy_mask),
        .arrival_dropped    (arrival_dropped),
        .queried_served     (queried_served),
        .queried_busy_ticks (queried_busy_ticks)
    );

endmodule

### src/msfd_checker.sv
`include "assert_macros.svh"

module msfd_checker
    import msfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] queue_length,
    input logic [6:0] peak_queue_length,
    input logic       arrival_dropped
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(queue_length))
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_len_le_peak, clk, rst_n, out_valid, queue_length <= peak_queue_length)
    `ASSERT_SAME(a_len_range, clk, rst_n, out_valid, queue_length <= 7'(FIFO_DEPTH))
    `ASSERT_SAME(a_drop_full, clk, rst_n, out_valid && arrival_dropped, peak_queue_length == 7'(FIFO_DEPTH))

endmodule

bind multi_server_fifo_dispatch_top msfd_checker u_msfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .queue_length      (queue_length),
    .peak_queue_length (peak_queue_length),
    .arrival_dropped   (arrival_dropped)
);
